FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define DSF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DSF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/dsfrx_pkg.sv
// shared types, constants and crc helper for the framed receiver
`default_nettype none

package dsfrx_pkg;

   localparam logic [7:0]  SYM_DLE  = 8'h90;
   localparam logic [7:0]  SYM_STX  = 8'h02;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   // parser phase; code 7 is unused and falls back to hunting for dle
   typedef enum logic [2:0] {
      PH_DLE,
      PH_STX,
      PH_OPCODE,
      PH_LEN,
      PH_DATA,
      PH_CRC1,
      PH_CRC2
   } phase_type;

   // operation handed from the parser to the crc / result side
   typedef enum logic [1:0] {
      OP_HDR,
      OP_DATA,
      OP_CRC_LO,
      OP_CRC_HI
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data_byte;
      logic [8:0]  byte_index;
      logic [7:0]  opcode;
      logic [7:0]  length_words;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // crc-16 ccitt, msb first, one byte shifted through the register
   function automatic logic [15:0] crc_feed_byte(input logic [15:0] crc_i,
                                                  input logic [7:0]  byte_i);
      logic [15:0] c;
      logic [7:0]  bits;
      logic        carry;
      c    = crc_i;
      bits = byte_i;
      for (int i = 0; i < 8; i++) begin
         carry = |(c & CRC_TOP);
         c     = {c[14:0], bits[7]};
         bits  = {bits[6:0], 1'b0};
         if (carry) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/dsfrx_queue.sv
// small fifo between the parser and the crc / result stage
`default_nettype none
`include "assert_macros.svh"

module dsfrx_queue #(
   parameter int DEPTH = 4
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push_valid,
   input  dsfrx_pkg::queue_entry_type   push_data,
   input  wire                          pop,
   output dsfrx_pkg::queue_entry_type   pop_data,
   output dsfrx_pkg::queue_status_type  status
);
   import dsfrx_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             full, empty, do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;

   assign status   = '{full: full, empty: empty};
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `DSF_ASSERT(a_count_in_range, clock, reset, count_ff <= CNT_W'(DEPTH), "queue overfilled")
   `DSF_ASSERT_NEXT(a_push_grows, clock, reset, do_push && !do_pop,
      count_ff == CNT_W'($past(count_ff) + CNT_W'(1)), "queue count lost a push")

endmodule

`default_nettype wire

FILE: rtl/dsfrx_front.sv
// byte parser: unstuffing, framing and classification of each received byte
`default_nettype none

module dsfrx_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [7:0]                   req_rx_byte,
   input  dsfrx_pkg::queue_status_type  queue_status,
   output logic                         push_valid,
   output dsfrx_pkg::queue_entry_type   push_data
);
   import dsfrx_pkg::*;

   phase_type  phase_ff, phase_in;
   logic       esc_ff, esc_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] opcode_ff, opcode_in;
   logic [8:0] count_ff, count_in;
   logic [8:0] count_next;
   logic       accept;
   logic [7:0] d;

   assign req_stall  = queue_status.full;
   assign accept     = req_valid && !queue_status.full;
   assign d          = req_rx_byte;
   assign count_next = count_ff + 9'd1;

   always_comb begin
      phase_in   = phase_ff;
      esc_in     = esc_ff;
      length_in  = length_ff;
      opcode_in  = opcode_ff;
      count_in   = count_ff;
      push_valid = 1'b0;
      push_data  = '{op: OP_HDR, data_byte: d, byte_index: count_ff,
                     opcode: opcode_ff, length_words: length_ff};
      if (accept) begin
         if (esc_ff && d == SYM_STX) begin
            // restart from any phase
            phase_in = PH_OPCODE;
            esc_in   = 1'b0;
         end else if (phase_ff == PH_DLE && d == SYM_DLE) begin
            phase_in = PH_STX;
         end else if (d == SYM_DLE && !esc_ff) begin
            esc_in = 1'b1;
         end else begin
            // doubled dle collapses to one data dle
            if (d == SYM_DLE) begin
               esc_in = 1'b0;
            end
            if (phase_ff == PH_STX && d == SYM_STX) begin
               phase_in = PH_OPCODE;
            end else begin
               unique case (phase_ff)
                  PH_OPCODE: begin
                     opcode_in = d;
                     phase_in  = PH_LEN;
                  end
                  PH_LEN: begin
                     length_in         = d;
                     count_in          = '0;
                     push_valid        = 1'b1;
                     push_data.op      = OP_HDR;
                     push_data.length_words = d;
                     phase_in          = (d == 8'd0) ? PH_CRC1 : PH_DATA;
                  end
                  PH_DATA: begin
                     push_valid   = 1'b1;
                     push_data.op = OP_DATA;
                     count_in     = count_next;
                     if (count_next == {length_ff, 1'b0}) begin
                        phase_in = PH_CRC1;
                     end
                  end
                  PH_CRC1: begin
                     push_valid   = 1'b1;
                     push_data.op = OP_CRC_LO;
                     phase_in     = PH_CRC2;
                  end
                  PH_CRC2: begin
                     push_valid   = 1'b1;
                     push_data.op = OP_CRC_HI;
                     phase_in     = PH_DLE;
                  end
                  default: begin
                     // bad sync or unused code
                     phase_in = PH_DLE;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DLE;
         esc_ff    <= 1'b0;
         length_ff <= '0;
         opcode_ff <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         esc_ff    <= esc_in;
         length_ff <= length_in;
         opcode_ff <= opcode_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dsfrx_back.sv
// crc accumulation and result register
`default_nettype none
`include "assert_macros.svh"

module dsfrx_back (
   input  wire                          clock,
   input  wire                          reset,
   input  dsfrx_pkg::queue_entry_type   pop_data,
   input  dsfrx_pkg::queue_status_type  queue_status,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic                         rsp_kind,
   output logic [7:0]                   rsp_data_byte,
   output logic [8:0]                   rsp_byte_index,
   output logic [7:0]                   rsp_opcode,
   output logic [7:0]                   rsp_length_words,
   output logic [15:0]                  rsp_received_crc,
   output logic                         rsp_crc_ok
);
   import dsfrx_pkg::*;

   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  data_byte_ff, data_byte_in;
   logic [8:0]  byte_index_ff, byte_index_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  length_ff, length_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic        crc_ok_ff, crc_ok_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  held_ff, held_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic        take, emit;
   logic [15:0] rx_word, fin_crc;

   // output slot free or being emptied this cycle
   assign take    = !valid_ff || !rsp_stall;
   assign pop     = take && !queue_status.empty;
   assign rx_word = {pop_data.data_byte, crc_low_ff};
   assign fin_crc = crc_feed_byte(crc_feed_byte(crc_ff, 8'd0), 8'd0);

   always_comb begin
      crc_in        = crc_ff;
      held_in       = held_ff;
      crc_low_in    = crc_low_ff;
      emit          = 1'b0;
      kind_in       = kind_ff;
      data_byte_in  = data_byte_ff;
      byte_index_in = byte_index_ff;
      opcode_in     = opcode_ff;
      length_in     = length_ff;
      rx_crc_in     = rx_crc_ff;
      crc_ok_in     = crc_ok_ff;
      if (pop) begin
         unique case (pop_data.op)
            OP_HDR: begin
               crc_in = crc_feed_byte(crc_feed_byte(16'd0, pop_data.length_words),
                                      pop_data.opcode);
            end
            OP_DATA: begin
               emit          = 1'b1;
               kind_in       = 1'b0;
               data_byte_in  = pop_data.data_byte;
               byte_index_in = pop_data.byte_index;
               opcode_in     = '0;
               length_in     = '0;
               rx_crc_in     = '0;
               crc_ok_in     = 1'b0;
               if (!pop_data.byte_index[0]) begin
                  held_in = pop_data.data_byte;
               end else begin
                  // word goes in high byte first
                  crc_in = crc_feed_byte(crc_feed_byte(crc_ff, pop_data.data_byte), held_ff);
               end
            end
            OP_CRC_LO: begin
               crc_low_in = pop_data.data_byte;
            end
            OP_CRC_HI: begin
               emit          = 1'b1;
               kind_in       = 1'b1;
               data_byte_in  = '0;
               byte_index_in = '0;
               opcode_in     = pop_data.opcode;
               length_in     = pop_data.length_words;
               rx_crc_in     = rx_word;
               crc_ok_in     = (fin_crc == rx_word);
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
      valid_in = take ? emit : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff        <= crc_in;
      held_ff       <= held_in;
      crc_low_ff    <= crc_low_in;
      kind_ff       <= kind_in;
      data_byte_ff  <= data_byte_in;
      byte_index_ff <= byte_index_in;
      opcode_ff     <= opcode_in;
      length_ff     <= length_in;
      rx_crc_ff     <= rx_crc_in;
      crc_ok_ff     <= crc_ok_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_data_byte    = data_byte_ff;
   assign rsp_byte_index   = byte_index_ff;
   assign rsp_opcode       = opcode_ff;
   assign rsp_length_words = length_ff;
   assign rsp_received_crc = rx_crc_ff;
   assign rsp_crc_ok       = crc_ok_ff;

   `DSF_ASSERT_NEXT(a_data_gives_byte, clock, reset, pop && pop_data.op == OP_DATA,
      rsp_valid && !rsp_kind, "data op did not produce a byte result")
   `DSF_ASSERT_NEXT(a_crc_hi_gives_done, clock, reset, pop && pop_data.op == OP_CRC_HI,
      rsp_valid && rsp_kind, "crc high op did not produce a done result")

endmodule

`default_nettype wire

FILE: rtl/dle_stx_frame_receiver_crc16_top.sv
// top level of the dle/stx framed receiver with crc-16 check
//
//   channel  | ports                      | moves
//   ---------+----------------------------+---------------------------------------
//   req      | req_valid / req_stall      | one raw received byte per transfer
//   rsp      | rsp_valid / rsp_stall      | one payload byte or one frame summary
//
// one byte is taken per cycle while req_stall is low and is classified in that cycle
// a result is registered: the queue entry written when its byte is taken is popped,
//   when the result slot is free, into the crc / result register, which also holds
//   the unrolled 16-bit crc update
// synchronous active-high reset clears the parser state, queue pointers and rsp_valid
// rsp_stall holds the result register; the queue absorbs QUEUE_DEPTH header, data
//   and crc operations before req_stall rises (queue full)
`default_nettype none

module dle_stx_frame_receiver_crc16_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [8:0]  rsp_byte_index,
   output logic [7:0]  rsp_opcode,
   output logic [7:0]  rsp_length_words,
   output logic [15:0] rsp_received_crc,
   output logic        rsp_crc_ok
);
   import dsfrx_pkg::*;

   // classified operations from parser to crc stage
   logic             push_valid;
   queue_entry_type  push_data;
   queue_entry_type  pop_data;
   queue_status_type queue_status;
   logic             pop;

   // front: unstuffing and frame parsing
   dsfrx_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   // decoupling queue
   dsfrx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .pop_data   (pop_data),
      .status     (queue_status)
   );

   // back: crc accumulation and result register
   dsfrx_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_data         (pop_data),
      .queue_status     (queue_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_opcode       (rsp_opcode),
      .rsp_length_words (rsp_length_words),
      .rsp_received_crc (rsp_received_crc),
      .rsp_crc_ok       (rsp_crc_ok)
   );

endmodule

`default_nettype wire
